@@ design/nep_pkg.sv @@
package nep_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DFL_VEL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DFL_GATE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DFL_OCT   = 2'd3;

	localparam logic [3:0]  RST_CHANNEL  = 4'd0;
	localparam logic [6:0]  RST_DFL_VEL  = 7'd100;
	localparam logic [14:0] RST_DFL_GATE = 15'd1;
	localparam logic [6:0]  RST_DFL_OCT  = 7'd4;

	localparam logic [7:0] ALL_NOTES = 8'd255;
	localparam logic [6:0] NOTE_MAX  = 7'd127;

	typedef enum logic [1:0] {
		KIND_NOTE = 2'd0,
		KIND_OFF  = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  event_channel;
		logic [7:0]  note;
		logic [6:0]  velocity;
		logic [14:0] gate_len;
		logic        end_flag;
	} out_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [6:0]  dfl_vel;
		logic [14:0] dfl_gate;
		logic [6:0]  dfl_oct;
	} cfg_t;

	typedef struct packed {
		logic       last;
		logic       blank;
		logic       digit;
		logic [3:0] dval;
		logic       alnum;
		logic       letter;
		logic [3:0] semi;
		logic       is_x;
		logic       is_o;
		logic       is_f;
		logic       sharp;
		logic       flat;
		logic       at;
		logic       vee;
		logic       tilde;
		logic       plus;
		logic       minus;
		logic       rest;
	} tok_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  oct;
		logic [11:0] semi;
		logic [6:0]  vel;
		logic [14:0] gate;
	} ev_t;

	typedef struct packed {
		ev_t [2:0]  ev;
		logic [1:0] cnt;
	} bnd_t;

	function automatic logic [3:0] letter_semi(logic [2:0] code);
		logic [3:0] s;
		case (code)
			3'd1:    s = 4'd9;
			3'd2:    s = 4'd11;
			3'd3:    s = 4'd0;
			3'd4:    s = 4'd2;
			3'd5:    s = 4'd4;
			3'd6:    s = 4'd5;
			3'd7:    s = 4'd7;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

@@ design/nep_front.sv @@
module nep_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nep_pkg::in_t  in_data,
	output logic          tok_valid,
	input  logic          tok_ready,
	output nep_pkg::tok_t tok
);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = " ";
	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_9     = "9";
	localparam logic [7:0] CH_LA    = "a";
	localparam logic [7:0] CH_LZ    = "z";
	localparam logic [7:0] CH_UA    = "A";
	localparam logic [7:0] CH_UG    = "G";
	localparam logic [7:0] CH_UZ    = "Z";
	localparam logic [7:0] CH_UX    = "X";
	localparam logic [7:0] CH_UO    = "O";
	localparam logic [7:0] CH_UF    = "F";
	localparam logic [7:0] CH_UV    = "V";
	localparam logic [7:0] CH_SHARP = "#";
	localparam logic [7:0] CH_FLAT  = "b";
	localparam logic [7:0] CH_AT    = "@";
	localparam logic [7:0] CH_TILDE = "~";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_REST  = "r";

	logic          vld_s1;
	nep_pkg::tok_t tok_s1;
	nep_pkg::tok_t cls;
	logic [7:0]    c;
	logic [7:0]    u;

	always_comb begin
		c = in_data.char_code;
		u = (c inside {[CH_LA:CH_LZ]}) ? c - 8'd32 : c;
		cls.last   = in_data.last;
		cls.blank  = (c == CH_SP) || (c inside {[CH_TAB:CH_CR]});
		cls.digit  = c inside {[CH_0:CH_9]};
		cls.dval   = c[3:0];
		cls.alnum  = cls.digit || (u inside {[CH_UA:CH_UZ]});
		cls.letter = u inside {[CH_UA:CH_UG]};
		cls.semi   = nep_pkg::letter_semi(u[2:0]);
		cls.is_x   = u == CH_UX;
		cls.is_o   = u == CH_UO;
		cls.is_f   = u == CH_UF;
		cls.sharp  = c == CH_SHARP;
		cls.flat   = c == CH_FLAT;
		cls.at     = c == CH_AT;
		cls.vee    = u == CH_UV;
		cls.tilde  = c == CH_TILDE;
		cls.plus   = c == CH_PLUS;
		cls.minus  = c == CH_MINUS;
		cls.rest   = c == CH_REST;
	end

	assign in_ready  = !vld_s1 || tok_ready;
	assign tok_valid = vld_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (tok_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_s1 <= cls;
		end
	end

endmodule

@@ design/nep_queue.sv @@
module nep_queue #(
	parameter int DEPTH = nep_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  nep_pkg::tok_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output nep_pkg::tok_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nep_pkg::tok_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = cnt_q != CNT_W'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/nep_parse.sv @@
module nep_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  nep_pkg::cfg_t cfg,
	input  logic          tok_valid,
	output logic          tok_ready,
	input  nep_pkg::tok_t tok,
	output logic          bnd_valid,
	input  logic          bnd_ready,
	output nep_pkg::bnd_t bnd
);

	typedef enum logic [12:0] {
		PH_START = 13'b0000000000001,
		PH_OFF   = 13'b0000000000010,
		PH_SINK  = 13'b0000000000100,
		PH_IDLE  = 13'b0000000001000,
		PH_ACC   = 13'b0000000010000,
		PH_OCT1  = 13'b0000000100000,
		PH_POST  = 13'b0000001000000,
		PH_VPRE  = 13'b0000010000000,
		PH_VSIGN = 13'b0000100000000,
		PH_VDIG  = 13'b0001000000000,
		PH_GPRE  = 13'b0010000000000,
		PH_GSIGN = 13'b0100000000000,
		PH_GDIG  = 13'b1000000000000
	} phase_t;

	localparam logic [3:0] SEMI_F = 4'd5;

	phase_t             phase_q;
	logic signed [11:0] semi_q;
	logic [3:0]         oct_q;
	logic [6:0]         poct_q;
	logic [15:0]        num_q;
	logic               neg_q;
	logic [6:0]         pvel_q;
	logic [1:0]         offcnt_q;

	phase_t             ph;
	logic signed [11:0] semi;
	logic [3:0]         oct;
	logic [6:0]         poct;
	logic [15:0]        num;
	logic               neg;
	logic [6:0]         pvel;
	logic [1:0]         offcnt;
	logic               go;
	logic               vside;
	logic               pre;
	logic [2:0]         n;
	nep_pkg::ev_t       ev [4];
	logic               pop;

	function automatic nep_pkg::ev_t mk_note(logic [6:0] o, logic [11:0] s, logic [6:0] v,
			logic [14:0] g);
		nep_pkg::ev_t e;
		e.kind = nep_pkg::KIND_NOTE;
		e.oct  = o;
		e.semi = s;
		e.vel  = v;
		e.gate = g;
		return e;
	endfunction

	function automatic nep_pkg::ev_t mk_mark(nep_pkg::kind_t k);
		nep_pkg::ev_t e;
		e      = '0;
		e.kind = k;
		return e;
	endfunction

	function automatic logic [15:0] acc10(logic [15:0] a, logic [3:0] d);
		logic [19:0] s;
		s = 20'(a) * 20'd10 + 20'(d);
		return (s > 20'd65535) ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [14:0] capval(logic [15:0] a, logic ng, logic [14:0] cap);
		logic [14:0] r;
		if (ng) begin
			r = '0;
		end else if (a > {1'b0, cap}) begin
			r = cap;
		end else begin
			r = a[14:0];
		end
		return r;
	endfunction

	always_comb begin
		ph     = phase_q;
		semi   = semi_q;
		oct    = oct_q;
		poct   = poct_q;
		num    = num_q;
		neg    = neg_q;
		pvel   = pvel_q;
		offcnt = offcnt_q;
		go     = 1'b1;
		vside  = 1'b0;
		pre    = 1'b0;
		n      = '0;
		for (int k = 0; k < 4; k++) begin
			ev[k] = '0;
		end

		for (int i = 0; i < 4; i++) begin
			if (go) begin
				go = 1'b0;
				case (ph)
					PH_START: begin
						if (tok.blank) begin
						end else if (tok.at || tok.rest || tok.minus) begin
							ph = PH_SINK;
						end else if (tok.is_x) begin
							ev[n[1:0]] = mk_mark(nep_pkg::KIND_OFF);
							n = n + 3'd1;
							ph = PH_SINK;
						end else if (tok.is_o) begin
							ph = PH_OFF;
							offcnt = 2'd1;
						end else begin
							ph = PH_IDLE;
							go = 1'b1;
						end
					end
					PH_SINK: begin
					end
					PH_OFF: begin
						if (tok.is_f && offcnt != 2'd3 && offcnt != 2'd0) begin
							offcnt = offcnt + 2'd1;
						end else if (offcnt == 2'd3) begin
							offcnt = 2'd0;
							if (!tok.alnum) begin
								ev[n[1:0]] = mk_mark(nep_pkg::KIND_OFF);
								n = n + 3'd1;
								ph = PH_SINK;
							end else begin
								ev[n[1:0]] = mk_note(cfg.dfl_oct, 12'(SEMI_F), cfg.dfl_vel,
									cfg.dfl_gate);
								n = n + 3'd1;
								semi = $signed({8'd0, SEMI_F});
								ph = PH_ACC;
								go = 1'b1;
							end
						end else begin
							if (offcnt == 2'd2) begin
								semi = $signed({8'd0, SEMI_F});
								ph = PH_ACC;
							end else begin
								ph = PH_IDLE;
							end
							offcnt = 2'd0;
							go = 1'b1;
						end
					end
					PH_IDLE: begin
						if (tok.letter) begin
							semi = $signed({8'd0, tok.semi});
							ph = PH_ACC;
						end
					end
					PH_ACC: begin
						if (tok.sharp) begin
							if (semi < 12'sd2047) begin
								semi = semi + 12'sd1;
							end
						end else if (tok.flat) begin
							if (semi > -12'sd2047) begin
								semi = semi - 12'sd1;
							end
						end else if (tok.digit) begin
							oct = tok.dval;
							ph = PH_OCT1;
						end else begin
							poct = cfg.dfl_oct;
							pvel = cfg.dfl_vel;
							ph = PH_POST;
							go = 1'b1;
						end
					end
					PH_OCT1: begin
						pvel = cfg.dfl_vel;
						ph = PH_POST;
						if (tok.digit) begin
							poct = 7'(oct) * 7'd10 + 7'(tok.dval);
						end else begin
							poct = 7'(oct);
							go = 1'b1;
						end
					end
					PH_POST: begin
						if (tok.at || tok.vee) begin
							num = '0;
							neg = 1'b0;
							ph = PH_VPRE;
						end else if (tok.tilde) begin
							num = '0;
							neg = 1'b0;
							ph = PH_GPRE;
						end else begin
							ev[n[1:0]] = mk_note(poct, semi, pvel, cfg.dfl_gate);
							n = n + 3'd1;
							ph = PH_IDLE;
							go = 1'b1;
						end
					end
					PH_VPRE, PH_VSIGN, PH_GPRE, PH_GSIGN: begin
						vside = (ph == PH_VPRE) || (ph == PH_VSIGN);
						pre   = (ph == PH_VPRE) || (ph == PH_GPRE);
						if (pre && (tok.plus || tok.minus)) begin
							neg = tok.minus;
							ph = vside ? PH_VSIGN : PH_GSIGN;
						end else if (tok.digit) begin
							num = acc10(num, tok.dval);
							ph = vside ? PH_VDIG : PH_GDIG;
						end else begin
							ev[n[1:0]] = mk_note(poct, semi, pvel, cfg.dfl_gate);
							n = n + 3'd1;
							ph = PH_IDLE;
							go = 1'b1;
						end
					end
					PH_VDIG: begin
						if (tok.digit) begin
							num = acc10(num, tok.dval);
						end else begin
							pvel = 7'(capval(num, neg, 15'(nep_pkg::NOTE_MAX)));
							if (tok.tilde) begin
								num = '0;
								neg = 1'b0;
								ph = PH_GPRE;
							end else begin
								ev[n[1:0]] = mk_note(poct, semi, pvel, cfg.dfl_gate);
								n = n + 3'd1;
								ph = PH_IDLE;
								go = 1'b1;
							end
						end
					end
					PH_GDIG: begin
						if (tok.digit) begin
							num = acc10(num, tok.dval);
						end else begin
							ev[n[1:0]] = mk_note(poct, semi, pvel, capval(num, neg, 15'h7FFF));
							n = n + 3'd1;
							ph = PH_IDLE;
							go = 1'b1;
						end
					end
					default: begin
						ph = PH_IDLE;
						go = 1'b1;
					end
				endcase
			end
		end

		if (tok.last) begin
			case (ph)
				PH_OFF: begin
					if (offcnt == 2'd2) begin
						ev[n[1:0]] = mk_note(cfg.dfl_oct, 12'(SEMI_F), cfg.dfl_vel, cfg.dfl_gate);
						n = n + 3'd1;
					end else if (offcnt == 2'd3) begin
						ev[n[1:0]] = mk_mark(nep_pkg::KIND_OFF);
						n = n + 3'd1;
					end
				end
				PH_ACC: begin
					ev[n[1:0]] = mk_note(cfg.dfl_oct, semi, cfg.dfl_vel, cfg.dfl_gate);
					n = n + 3'd1;
				end
				PH_OCT1: begin
					ev[n[1:0]] = mk_note(7'(oct), semi, cfg.dfl_vel, cfg.dfl_gate);
					n = n + 3'd1;
				end
				PH_POST, PH_VPRE, PH_VSIGN, PH_GPRE, PH_GSIGN: begin
					ev[n[1:0]] = mk_note(poct, semi, pvel, cfg.dfl_gate);
					n = n + 3'd1;
				end
				PH_VDIG: begin
					ev[n[1:0]] = mk_note(poct, semi, 7'(capval(num, neg, 15'(nep_pkg::NOTE_MAX))),
						cfg.dfl_gate);
					n = n + 3'd1;
				end
				PH_GDIG: begin
					ev[n[1:0]] = mk_note(poct, semi, pvel, capval(num, neg, 15'h7FFF));
					n = n + 3'd1;
				end
				default: begin
				end
			endcase
			ev[n[1:0]] = mk_mark(nep_pkg::KIND_END);
			n      = n + 3'd1;
			ph     = PH_START;
			semi   = '0;
			oct    = '0;
			poct   = '0;
			num    = '0;
			neg    = 1'b0;
			pvel   = '0;
			offcnt = '0;
		end

		bnd.ev[0] = ev[0];
		bnd.ev[1] = ev[1];
		bnd.ev[2] = (n == 3'd4) ? ev[3] : ev[2];
		bnd.cnt   = (n == 3'd4) ? 2'd3 : n[1:0];
	end

	assign tok_ready = (n == 3'd0) || bnd_ready;
	assign bnd_valid = tok_valid && (n != 3'd0);
	assign pop       = tok_valid && tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			semi_q   <= '0;
			oct_q    <= '0;
			poct_q   <= '0;
			num_q    <= '0;
			neg_q    <= 1'b0;
			pvel_q   <= '0;
			offcnt_q <= '0;
		end else if (pop) begin
			phase_q  <= ph;
			semi_q   <= semi;
			oct_q    <= oct;
			poct_q   <= poct;
			num_q    <= num;
			neg_q    <= neg;
			pvel_q   <= pvel;
			offcnt_q <= offcnt;
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && tok.last |=> phase_q == PH_START)
		else $error("expression did not restart after its last item");

	a_off_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OFF |-> offcnt_q != 2'd0)
		else $error("off match phase with empty match count");

	a_semi_range: assert property (@(posedge clk) disable iff (!arst_n)
		semi_q >= -12'sd2047)
		else $error("semitone total out of range");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_valid && bnd_ready && tok.last |->
			bnd.ev[bnd.cnt - 2'd1].kind == nep_pkg::KIND_END)
		else $error("last item does not close with an end marker");

endmodule

@@ design/nep_emit.sv @@
module nep_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  nep_pkg::cfg_t cfg,
	input  logic          bnd_valid,
	output logic          bnd_ready,
	input  nep_pkg::bnd_t bnd,
	output logic          out_valid,
	input  logic          out_ready,
	output nep_pkg::out_t out_data
);

	nep_pkg::ev_t       ev_q [3];
	logic [1:0]         cnt_q;
	nep_pkg::ev_t       head;
	logic [7:0]         o1;
	logic [10:0]        base;
	logic signed [13:0] m;
	logic [7:0]         note_on;

	assign out_valid = cnt_q != 2'd0;
	assign bnd_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign head      = ev_q[0];

	always_comb begin
		o1   = {1'b0, head.oct} + 8'd1;
		base = 11'(o1) * 11'd12;
		m    = $signed({3'b000, base}) + $signed({{2{head.semi[11]}}, head.semi});
		if (m < 14'sd0) begin
			note_on = '0;
		end else if (m > 14'sd127) begin
			note_on = {1'b0, nep_pkg::NOTE_MAX};
		end else begin
			note_on = {1'b0, m[6:0]};
		end

		out_data.kind          = head.kind;
		out_data.event_channel = cfg.channel;
		out_data.end_flag      = 1'b0;
		case (head.kind)
			nep_pkg::KIND_NOTE: begin
				out_data.note     = note_on;
				out_data.velocity = head.vel;
				out_data.gate_len = head.gate;
			end
			nep_pkg::KIND_OFF: begin
				out_data.note     = nep_pkg::ALL_NOTES;
				out_data.velocity = '0;
				out_data.gate_len = '0;
			end
			default: begin
				out_data.note     = '0;
				out_data.velocity = '0;
				out_data.gate_len = '0;
				out_data.end_flag = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (bnd_valid && bnd_ready) begin
			cnt_q <= bnd.cnt;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_valid && bnd_ready) begin
			ev_q[0] <= bnd.ev[0];
			ev_q[1] <= bnd.ev[1];
			ev_q[2] <= bnd.ev[2];
		end else if (out_valid && out_ready) begin
			ev_q[0] <= ev_q[1];
			ev_q[1] <= ev_q[2];
		end
	end

endmodule

@@ design/note_expression_parser.sv @@
// Note expression parser: reads note text one ASCII byte per item and emits
// MIDI events (note-on, all-notes-off, end marker).
// Input channel in_valid/in_ready/in_data carries one byte and its last flag;
// output channel out_valid/out_ready/out_data carries one event per item.
// Every expression closes with an end marker event (end_flag set).
// Configuration: pulse cfg_we with cfg_idx/cfg_wdata; 0 channel, 1 default
// velocity, 2 default gate, 3 default octave. Write only while idle.
// Path: a byte is registered in the classify stage, written into the queue, then
// parsed combinationally into the output register.
// Throughput: one byte per cycle while out_ready is high and each byte yields at
// most one event; a byte that yields several events holds the parser while the
// output register drains, one event per cycle while out_ready is high. The queue
// between classifier and parser holds QUEUE_DEPTH bytes.
// Reset: asynchronous, active low; clears all parse state, empties the queue
// and output register, and loads the register defaults (channel 0, velocity
// 100, gate 1, octave 4).
// Stall: with out_ready low the held event stays stable; the parser stops,
// the queue fills, then in_ready drops.
module note_expression_parser #(
	parameter int QUEUE_DEPTH = nep_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  nep_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output nep_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [nep_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [nep_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	nep_pkg::cfg_t cfg_q;
	nep_pkg::tok_t f_tok;
	nep_pkg::tok_t q_tok;
	nep_pkg::bnd_t bnd;
	logic          f_valid;
	logic          f_ready;
	logic          q_valid;
	logic          q_ready;
	logic          bnd_valid;
	logic          bnd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel  <= nep_pkg::RST_CHANNEL;
			cfg_q.dfl_vel  <= nep_pkg::RST_DFL_VEL;
			cfg_q.dfl_gate <= nep_pkg::RST_DFL_GATE;
			cfg_q.dfl_oct  <= nep_pkg::RST_DFL_OCT;
		end else if (cfg_we) begin
			case (cfg_idx)
				nep_pkg::CFG_CHANNEL:  cfg_q.channel  <= cfg_wdata[3:0];
				nep_pkg::CFG_DFL_VEL:  cfg_q.dfl_vel  <= cfg_wdata[6:0];
				nep_pkg::CFG_DFL_GATE: cfg_q.dfl_gate <= cfg_wdata[14:0];
				nep_pkg::CFG_DFL_OCT:  cfg_q.dfl_oct  <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	nep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	nep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_tok)
	);

	nep_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd)
	);

	nep_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/tb_note_expression_parser.sv @@
`timescale 1ns / 100ps

module tb_note_expression_parser;

	typedef enum int {
		PH_START, PH_OFF, PH_SINK, PH_IDLE, PH_ACC, PH_OCT1, PH_POST,
		PH_VPRE, PH_VSIGN, PH_VDIG, PH_GPRE, PH_GSIGN, PH_GDIG
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	nep_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	nep_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [nep_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [nep_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	note_expression_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// parser shadow state and register copies
	int cfg_channel = nep_pkg::RST_CHANNEL;
	int cfg_vel = nep_pkg::RST_DFL_VEL;
	int cfg_gate = nep_pkg::RST_DFL_GATE;
	int cfg_oct = nep_pkg::RST_DFL_OCT;
	parse_phase_t phase_q = PH_START;
	int semis = 0;
	int oct_digit = 0;
	int num_acc = 0;
	bit num_neg = 1'b0;
	int held_note = 0;
	int held_vel = 0;
	int off_cnt = 0;

	nep_pkg::out_t step_events[$];
	nep_pkg::out_t midi_due[$];
	logic [7:0] expr_bytes[$];

	int err_count = 0;
	int sent_items = 0;
	bit idle_on = 1'b0;
	int hold_cnt = 0;

	function automatic bit is_blank(input int c);
		return c == 32 || (c >= 9 && c <= 13);
	endfunction

	function automatic bit is_digit(input int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alnum(input int c);
		return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic int letter_pitch(input int up);
		case (up)
			"A": return 9;
			"B": return 11;
			"C": return 0;
			"D": return 2;
			"E": return 4;
			"F": return 5;
			default: return 7;
		endcase
	endfunction

	function automatic void add_event(input nep_pkg::kind_t k, input int note, input int vel,
			input int gate);
		nep_pkg::out_t e;
		if (step_events.size() < 6) begin
			e.kind = k;
			e.event_channel = cfg_channel[3:0];
			e.note = note[7:0];
			e.velocity = vel[6:0];
			e.gate_len = gate[14:0];
			e.end_flag = (k == nep_pkg::KIND_END);
			step_events.push_back(e);
		end
	endfunction

	function automatic void place_note(input int oct);
		int m;
		m = (oct + 1) * 12 + semis;
		if (m < 0) m = 0;
		if (m > 127) m = 127;
		held_note = m;
		held_vel = cfg_vel;
		phase_q = PH_POST;
	endfunction

	function automatic void push_digit(input int c);
		int n;
		n = num_acc * 10 + (c - "0");
		num_acc = (n > 65535) ? 65535 : n;
	endfunction

	function automatic int clamp_number(input int cap);
		if (num_neg) return 0;
		return (num_acc > cap) ? cap : num_acc;
	endfunction

	function automatic void start_number();
		num_acc = 0;
		num_neg = 1'b0;
	endfunction

	function automatic void feed_char(input int c);
		int u;
		bit done;
		done = 1'b0;
		while (!done) begin
			u = (c >= "a" && c <= "z") ? c - 32 : c;
			case (phase_q)
				PH_START: begin
					if (is_blank(c)) begin
						done = 1'b1;
					end else if (c == "@" || c == "r" || c == "-") begin
						phase_q = PH_SINK;
						done = 1'b1;
					end else if (u == "X") begin
						add_event(nep_pkg::KIND_OFF, nep_pkg::ALL_NOTES, 0, 0);
						phase_q = PH_SINK;
						done = 1'b1;
					end else if (u == "O") begin
						phase_q = PH_OFF;
						off_cnt = 1;
						done = 1'b1;
					end else begin
						phase_q = PH_IDLE;
					end
				end
				PH_SINK: done = 1'b1;
				PH_OFF: begin
					if (u == "F" && off_cnt < 3) begin
						off_cnt++;
						done = 1'b1;
					end else if (off_cnt == 3) begin
						off_cnt = 0;
						if (!is_alnum(c)) begin
							add_event(nep_pkg::KIND_OFF, nep_pkg::ALL_NOTES, 0, 0);
							phase_q = PH_SINK;
							done = 1'b1;
						end else begin
							// first held f plays as a plain F, second one starts a note
							semis = letter_pitch("F");
							place_note(cfg_oct);
							add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
							semis = letter_pitch("F");
							phase_q = PH_ACC;
						end
					end else begin
						if (off_cnt == 2) begin
							semis = letter_pitch("F");
							phase_q = PH_ACC;
						end else begin
							phase_q = PH_IDLE;
						end
						off_cnt = 0;
					end
				end
				PH_IDLE: begin
					if (u >= "A" && u <= "G") begin
						semis = letter_pitch(u);
						phase_q = PH_ACC;
					end
					done = 1'b1;
				end
				PH_ACC: begin
					if (c == "#") begin
						if (semis < 2047) semis++;
						done = 1'b1;
					end else if (c == "b") begin
						if (semis > -2047) semis--;
						done = 1'b1;
					end else if (is_digit(c)) begin
						oct_digit = c - "0";
						phase_q = PH_OCT1;
						done = 1'b1;
					end else begin
						place_note(cfg_oct);
					end
				end
				PH_OCT1: begin
					if (is_digit(c)) begin
						place_note(oct_digit * 10 + (c - "0"));
						done = 1'b1;
					end else begin
						place_note(oct_digit);
					end
				end
				PH_POST: begin
					if (c == "@" || u == "V") begin
						start_number();
						phase_q = PH_VPRE;
						done = 1'b1;
					end else if (c == "~") begin
						start_number();
						phase_q = PH_GPRE;
						done = 1'b1;
					end else begin
						add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
						phase_q = PH_IDLE;
					end
				end
				PH_VPRE, PH_GPRE, PH_VSIGN, PH_GSIGN: begin
					if ((phase_q == PH_VPRE || phase_q == PH_GPRE) && (c == "+" || c == "-")) begin
						num_neg = (c == "-");
						phase_q = (phase_q == PH_VPRE) ? PH_VSIGN : PH_GSIGN;
						done = 1'b1;
					end else if (is_digit(c)) begin
						push_digit(c);
						phase_q = (phase_q == PH_VPRE || phase_q == PH_VSIGN) ? PH_VDIG : PH_GDIG;
						done = 1'b1;
					end else begin
						add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
						phase_q = PH_IDLE;
					end
				end
				PH_VDIG: begin
					if (is_digit(c)) begin
						push_digit(c);
						done = 1'b1;
					end else begin
						held_vel = clamp_number(127);
						if (c == "~") begin
							start_number();
							phase_q = PH_GPRE;
							done = 1'b1;
						end else begin
							add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
							phase_q = PH_IDLE;
						end
					end
				end
				default: begin
					if (is_digit(c)) begin
						push_digit(c);
						done = 1'b1;
					end else begin
						add_event(nep_pkg::KIND_NOTE, held_note, held_vel, clamp_number(32767));
						phase_q = PH_IDLE;
					end
				end
			endcase
		end
	endfunction

	function automatic void close_expression();
		case (phase_q)
			PH_OFF: begin
				if (off_cnt == 2) begin
					semis = letter_pitch("F");
					place_note(cfg_oct);
					add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
				end else if (off_cnt == 3) begin
					add_event(nep_pkg::KIND_OFF, nep_pkg::ALL_NOTES, 0, 0);
				end
			end
			PH_ACC: begin
				place_note(cfg_oct);
				add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
			end
			PH_OCT1: begin
				place_note(oct_digit);
				add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
			end
			PH_POST, PH_VPRE, PH_VSIGN, PH_GPRE, PH_GSIGN:
				add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
			PH_VDIG: begin
				held_vel = clamp_number(127);
				add_event(nep_pkg::KIND_NOTE, held_note, held_vel, cfg_gate);
			end
			PH_GDIG: add_event(nep_pkg::KIND_NOTE, held_note, held_vel, clamp_number(32767));
			default: ;
		endcase
		add_event(nep_pkg::KIND_END, 0, 0, 0);
		phase_q = PH_START;
		semis = 0;
		oct_digit = 0;
		num_acc = 0;
		num_neg = 1'b0;
		held_note = 0;
		held_vel = 0;
		off_cnt = 0;
	endfunction

	function automatic void parse_char(input logic [7:0] c, input logic last);
		int n;
		step_events.delete();
		feed_char(c);
		if (last) close_expression();
		n = step_events.size();
		// keep the end marker when a step overflows
		if (n > 3) begin
			step_events[2] = step_events[n-1];
			n = 3;
		end
		for (int i = 0; i < n; i++) midi_due.push_back(step_events[i]);
	endfunction

	function automatic string event_text(input nep_pkg::out_t e);
		return $sformatf("kind=%0d ch=%0d note=%0d vel=%0d gate=%0d end=%0b",
			e.kind, e.event_channel, e.note, e.velocity, e.gate_len, e.end_flag);
	endfunction

	always @(posedge clk) begin : check_events
		nep_pkg::out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) parse_char(in_data.char_code, in_data.last);
			if (out_valid && out_ready) begin
				if (midi_due.size() == 0) begin
					err_count++;
					if (err_count <= 10) $display("unexpected event: %s", event_text(out_data));
				end else begin
					want = midi_due.pop_front();
					if (out_data.kind !== want.kind ||
							out_data.event_channel !== want.event_channel ||
							out_data.note !== want.note || out_data.velocity !== want.velocity ||
							out_data.gate_len !== want.gate_len ||
							out_data.end_flag !== want.end_flag) begin
						err_count++;
						if (err_count <= 10)
							$display("event mismatch: want %s got %s", event_text(want),
								event_text(out_data));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(3, 30) : $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {c, last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_expression();
		for (int i = 0; i < expr_bytes.size(); i++)
			send_char(expr_bytes[i], i == expr_bytes.size() - 1);
	endtask

	task automatic send_text(input string s);
		expr_bytes.delete();
		for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
		send_expression();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (midi_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nep_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[nep_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_config(input int ch, input int vel, input int gate, input int oct);
		wait_idle();
		write_reg(nep_pkg::CFG_CHANNEL, ch);
		write_reg(nep_pkg::CFG_DFL_VEL, vel);
		write_reg(nep_pkg::CFG_DFL_GATE, gate);
		write_reg(nep_pkg::CFG_DFL_OCT, oct);
		cfg_we <= 1'b0;
		cfg_channel = ch;
		cfg_vel = vel;
		cfg_gate = gate;
		cfg_oct = oct;
	endtask

	function automatic void put(input int c);
		expr_bytes.push_back(c[7:0]);
	endfunction

	function automatic void put_digits(input int n);
		for (int i = 0; i < n; i++) put("0" + $urandom_range(0, 9));
	endfunction

	function automatic void put_number();
		int r;
		if ($urandom_range(0, 4) == 0) put($urandom_range(0, 1) ? "+" : "-");
		r = $urandom_range(0, 99);
		put_digits(r < 10 ? 0 : r < 92 ? $urandom_range(1, 3) : $urandom_range(4, 6));
	endfunction

	function automatic void put_note();
		int n;
		put("A" + $urandom_range(0, 6) + ($urandom_range(0, 1) ? 32 : 0));
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		for (int i = 0; i < n; i++) put($urandom_range(0, 1) ? "#" : "b");
		n = $urandom_range(0, 99);
		if (n < 60) put_digits(n < 40 ? 1 : n < 57 ? 2 : 3);
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 2))
				0: put("@");
				1: put("v");
				default: put("V");
			endcase
			put_number();
		end
		if ($urandom_range(0, 2) == 0) begin
			put("~");
			put_number();
		end
	endfunction

	function automatic void put_gap();
		case ($urandom_range(0, 9))
			0, 1, 2: put(" ");
			3: put(",");
			4: put("|");
			5: put(8'h09);
			6: put(8'h0a);
			7: put($urandom_range(0, 255));
			default: ;
		endcase
	endfunction

	function automatic void put_either(input int up);
		put($urandom_range(0, 1) ? up : up + 32);
	endfunction

	function automatic void build_expression();
		int r;
		int n;
		expr_bytes.delete();
		if ($urandom_range(0, 4) == 0) put(" ");
		r = $urandom_range(0, 99);
		if (r < 55) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				put_note();
				put_gap();
			end
		end else if (r < 63) begin
			put_either("O");
			put_either("F");
			put_either("F");
			if ($urandom_range(0, 1)) put_gap();
		end else if (r < 68) begin
			put_either("X");
			if ($urandom_range(0, 1)) put_note();
		end else if (r < 73) begin
			put($urandom_range(0, 1) ? "r" : "-");
			put_note();
		end else if (r < 77) begin
			put("@");
			put_note();
		end else if (r < 85) begin
			n = $urandom_range(1, 3);
			put_either("O");
			for (int i = 1; i < n; i++) put_either("F");
			if ($urandom_range(0, 2) != 0) put_note();
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) put($urandom_range(0, 255));
		end
	endfunction

	task automatic random_phrases(input int count, input bit with_pauses);
		int stop_at;
		stop_at = sent_items + count;
		while (sent_items < stop_at) begin
			idle_on = ($urandom_range(0, 7) != 0);
			build_expression();
			send_expression();
			if (with_pauses && $urandom_range(0, 11) == 0) wait_idle();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		send_text("x");
		send_text("ofa");
		send_text("offg");
		send_text("@c");
		send_text("rA");
		send_text("b99v-3");
		send_text("E~70000");
		send_text("D@~");
		send_text("a123");
		expr_bytes = '{8'h00, 8'hff, "g", 8'h80};
		send_expression();
	endtask

	task automatic test_accidental_runs();
		idle_on = 1'b0;
		expr_bytes.delete();
		put("C");
		repeat (9) put("b");
		repeat (12) put("#");
		send_expression();
		expr_bytes.delete();
		put("g");
		repeat (10) put("#");
		repeat (6) put("b");
		send_expression();
		idle_on = 1'b1;
	endtask

	task automatic test_config_extremes();
		set_config(15, 127, 32767, 99);
		random_phrases(35, 1'b0);
		set_config(0, 0, 0, 0);
		random_phrases(35, 1'b0);
	endtask

	task automatic test_random_stream();
		set_config($urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 40),
			$urandom_range(0, 9));
		random_phrases(70, 1'b1);
		set_config($urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 32767),
			$urandom_range(0, 99));
		random_phrases(70, 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_accidental_runs();
		test_config_extremes();
		test_random_stream();
		wait_idle();
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
